FILE: rtl/core/ray_triangle_intersect_assert.svh
// Assertion macros shared by the ray triangle intersection RTL
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle
`define RTI_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle
`define RTI_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: rtl/core/rti_pkg.sv
// Shared types and constants for the ray triangle intersection block
package rti_pkg;
	localparam int DIST_W = 32;
	localparam logic [1:0] REG_V0 = 2'd0;
	localparam logic [1:0] REG_V1 = 2'd1;
	localparam logic [1:0] REG_V2 = 2'd2;
	typedef struct packed {
		logic hit;
		logic [DIST_W-1:0] distance;
	} rti_result_t;
endpackage

FILE: rtl/core/rti_divider.sv
// Pipelined restoring divider: one quotient bit per stage
module rti_divider #(
	parameter int NUM_W = 96
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_hit,
	input  logic in_sat,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	output logic out_valid,
	output rti_pkg::rti_result_t out_res
);
	import rti_pkg::*;
	localparam int NS = DIST_W;
	localparam int RW = NUM_W + DIST_W + 1;

	logic v_s [NS+1];
	logic h_s [NS+1];
	logic sat_s [NS+1];
	logic [RW-1:0] rem_s [NS+1];
	logic [NUM_W-1:0] den_s [NS+1];
	logic [DIST_W-1:0] q_s [NS+1];

	// load the numerator scaled by 2^16
	assign v_s[0] = in_valid;
	assign h_s[0] = in_hit;
	assign sat_s[0] = in_sat;
	assign rem_s[0] = {{(RW-NUM_W){1'b0}}, num} << 16;
	assign den_s[0] = den;
	assign q_s[0] = '0;

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < NS; i++) begin : g_st
		localparam int SH = NS - 1 - i;
		logic [RW-1:0] c;
		logic ge;
		assign c = {{(RW-NUM_W){1'b0}}, den_s[i]} << SH;
		assign ge = rem_s[i] >= c;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			h_s[i+1] <= h_s[i];
			sat_s[i+1] <= sat_s[i];
			den_s[i+1] <= den_s[i];
			rem_s[i+1] <= ge ? rem_s[i] - c : rem_s[i];
			q_s[i+1] <= q_s[i] | (ge ? (DIST_W'(1) << SH) : '0);
		end
	end

	// form the result word
	assign out_valid = v_s[NS];
	assign out_res.hit = h_s[NS];
	assign out_res.distance = !h_s[NS] ? '0 : (sat_s[NS] ? '1 : q_s[NS]);
endmodule

FILE: rtl/core/ray_triangle_intersect.sv
// Top level of the ray triangle intersection pipeline
// Channel | Ports                                   | Handshake
// cmd     | origin_*, dir_*                          | start && !busy
// cfg     | cfg_index, cfg_data                      | cfg_valid && cfg_ready
// result  | hit, distance                            | done strobe, one cycle
// A ray enters every cycle; its result passes through four
// arithmetic stages and one stage per quotient bit of the 32 bit divider.
// Reset clears the valid bits and vertices; busy is always low.
module ray_triangle_intersect #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	input  logic signed [COORD_BITS-1:0] origin_z,
	input  logic signed [COORD_BITS-1:0] dir_x,
	input  logic signed [COORD_BITS-1:0] dir_y,
	input  logic signed [COORD_BITS-1:0] dir_z,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3*COORD_BITS-1:0] cfg_data,
	output logic done,
	output logic hit,
	output logic [31:0] distance
);
	import rti_pkg::*;
	`include "ray_triangle_intersect_assert.svh"
	localparam int CW = COORD_BITS;
	localparam int EW = CW + 1;
	localparam int CRW = 2*EW + 2;
	localparam int DW = CRW + EW + 3;
	localparam int NW = DW + 1;

	logic [3*CW-1:0] v0_q, v1_q, v2_q;
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// store the vertex registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= '0; v1_q <= '0; v2_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_V0: v0_q <= cfg_data;
				REG_V1: v1_q <= cfg_data;
				REG_V2: v2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [EW-1:0] crd(input logic [3*CW-1:0] v, input int k);
		return EW'($signed(v[k*CW +: CW]));
	endfunction

	// stage 1: edges and offset
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], s_s1 [3], d_s1 [3];
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [CW-1:0] o_in [3], d_in [3];
	assign o_in = '{origin_x, origin_y, origin_z};
	assign d_in = '{dir_x, dir_y, dir_z};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= start; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e1_s1[k] <= crd(v1_q, k) - crd(v0_q, k);
			e2_s1[k] <= crd(v2_q, k) - crd(v0_q, k);
			s_s1[k] <= EW'(o_in[k]) - crd(v0_q, k);
			d_s1[k] <= EW'(d_in[k]);
		end
	end

	// stage 2: cross products H = D x E2, Q = S x E1
	logic signed [EW-1:0] e1_s2 [3], e2_s2 [3], s_s2 [3], d_s2 [3];
	logic signed [CRW-1:0] h_s2 [3], q_s2 [3];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			h_s2[k] <= CRW'(d_s1[(k+1)%3]) * CRW'(e2_s1[(k+2)%3])
				- CRW'(d_s1[(k+2)%3]) * CRW'(e2_s1[(k+1)%3]);
			q_s2[k] <= CRW'(s_s1[(k+1)%3]) * CRW'(e1_s1[(k+2)%3])
				- CRW'(s_s1[(k+2)%3]) * CRW'(e1_s1[(k+1)%3]);
		end
		e1_s2 <= e1_s1; e2_s2 <= e2_s1; s_s2 <= s_s1; d_s2 <= d_s1;
	end

	// stage 3: the four dot products
	logic signed [DW-1:0] det_s3, u_s3, w_s3, t_s3;
	function automatic logic signed [DW-1:0] dot(
		input logic signed [EW-1:0] a [3], input logic signed [CRW-1:0] b [3]);
		return DW'(a[0]) * DW'(b[0]) + DW'(a[1]) * DW'(b[1]) + DW'(a[2]) * DW'(b[2]);
	endfunction
	always_ff @(posedge clk) begin
		det_s3 <= dot(e1_s2, h_s2);
		u_s3 <= dot(s_s2, h_s2);
		w_s3 <= dot(d_s2, q_s2);
		t_s3 <= dot(e2_s2, q_s2);
	end

	// stage 4: fold signs to det and test the bounds
	logic signed [NW-1:0] dp, up, wp, tp;
	logic inb;
	always_comb begin
		dp = det_s3[DW-1] ? -NW'(det_s3) : NW'(det_s3);
		up = det_s3[DW-1] ? -NW'(u_s3) : NW'(u_s3);
		wp = det_s3[DW-1] ? -NW'(w_s3) : NW'(w_s3);
		tp = det_s3[DW-1] ? -NW'(t_s3) : NW'(t_s3);
		inb = (dp != 0) && !up[NW-1] && (up <= dp) && !wp[NW-1]
			&& ((up + wp) <= dp) && !tp[NW-1] && (tp != 0);
	end
	logic h_s4, sat_s4;
	logic [NW-1:0] t_s4, d_s4;
	always_ff @(posedge clk) begin
		h_s4 <= inb;
		sat_s4 <= ({16'd0, tp} >= ({16'd0, dp} << 16));
		t_s4 <= inb ? NW'(tp) : '0;
		d_s4 <= inb ? NW'(dp) : NW'(1);
	end

	rti_result_t res;
	rti_divider #(.NUM_W(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s4), .in_hit(h_s4),
		.in_sat(sat_s4), .num(t_s4), .den(d_s4),
		.out_valid(done), .out_res(res));
	assign hit = done & res.hit;
	assign distance = done ? res.distance : '0;

	`RTI_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !hit, distance == 0)
	`RTI_ASSERT_NXT(a_s1_follow, clk, arst_n, start, v_s1)
	`RTI_ASSERT_IMP(a_no_busy, clk, arst_n, start, !busy)
endmodule
